### hdl/sisd_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the sorted insert stack with duplicate removal; no dependencies
package sisd_pkg;

    localparam int DEPTH  = 32;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int CMD_W  = 3;
    localparam int DATA_W = 8;
    localparam int OCC_W  = 6;
    localparam int STAT_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEDUP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // datapath micro-operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH,
        DP_RD_TOP,
        DP_POP,
        DP_INS_START,
        DP_INS_STEP,
        DP_DD_START,
        DP_DD_LOAD,
        DP_DD_CAND,
        DP_DD_SCAN,
        DP_DD_END,
        DP_RO_START,
        DP_RO_RD,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [STAT_W-1:0]   status;
        logic                zero;
        logic                last;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic                empty;
        logic                full;
        logic                ins_shift;
        logic                dd_i_done;
        logic                dd_cand_last;
        logic                dd_scan_hit;
        logic                dd_scan_last;
        logic                ro_last;
        logic                out_free;
    } t_dp_stat;

endpackage

### hdl/sisd_datapath.sv
// datapath: entry memory, count and walk pointers, output register
// depends on sisd_pkg
module sisd_datapath import sisd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [DATA_W-1:0] i_data_value,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic [OCC_W-1:0]         o_occupancy,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_last
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    logic [CMD_W-1:0]         r_cmd, n_cmd;
    logic signed [DATA_W-1:0] r_data, n_data;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_ptr, n_ptr;
    logic [CW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_wr, n_wr;
    logic [CW-1:0]            r_scan, n_scan;
    logic signed [DATA_W-1:0] r_cand, n_cand;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic [OCC_W-1:0]         r_out_occ;
    logic [STAT_W-1:0]        r_out_status;
    logic                     r_out_last;

    logic                     rd_en, wr_en, load_out;
    logic [AW-1:0]            rd_addr, wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [CW-1:0]            count_m1, ptr_m1, ptr_m2, idx_p1, scan_p1, wr_p1;
    logic                     out_free, ins_shift, cand_last, scan_hit, scan_last;

    assign count_m1  = r_count - CW'(1);
    assign ptr_m1    = r_ptr - CW'(1);
    assign ptr_m2    = r_ptr - CW'(2);
    assign idx_p1    = r_idx + CW'(1);
    assign scan_p1   = r_scan + CW'(1);
    assign wr_p1     = r_wr + CW'(1);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign ins_shift = (r_ptr != '0) && (r_rd_data < r_data);
    assign cand_last = idx_p1 >= r_count;
    assign scan_hit  = r_rd_data == r_cand;
    assign scan_last = scan_p1 >= r_count;

    always_comb begin
        o_stat.cmd          = r_cmd;
        o_stat.empty        = r_count == '0;
        o_stat.full         = r_count == CW'(DEPTH);
        o_stat.ins_shift    = ins_shift;
        o_stat.dd_i_done    = r_idx >= r_count;
        o_stat.dd_cand_last = cand_last;
        o_stat.dd_scan_hit  = scan_hit;
        o_stat.dd_scan_last = scan_last;
        o_stat.ro_last      = r_ptr == '0;
        o_stat.out_free     = out_free;
    end

    always_comb begin
        n_cmd    = r_cmd;
        n_data   = r_data;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_idx    = r_idx;
        n_wr     = r_wr;
        n_scan   = r_scan;
        n_cand   = r_cand;
        rd_en    = 1'b0;
        rd_addr  = count_m1[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_count[AW-1:0];
        wr_data  = r_data;
        load_out = 1'b0;
        case (i_cmd.op)
            DP_LOAD: begin
                n_cmd  = i_command;
                n_data = i_data_value;
            end
            DP_PUSH: begin
                wr_en   = 1'b1;
                n_count = r_count + CW'(1);
            end
            DP_RD_TOP: begin
                rd_en = 1'b1;
            end
            DP_POP: begin
                rd_en   = 1'b1;
                n_count = count_m1;
            end
            DP_INS_START: begin
                n_ptr = r_count;
                rd_en = 1'b1;
            end
            DP_INS_STEP: begin
                // r_rd_data holds the entry just below r_ptr
                wr_en   = 1'b1;
                wr_addr = r_ptr[AW-1:0];
                if (ins_shift) begin
                    wr_data = r_rd_data;
                    n_ptr   = ptr_m1;
                    rd_en   = 1'b1;
                    rd_addr = ptr_m2[AW-1:0];
                end else begin
                    wr_data = r_data;
                    n_count = r_count + CW'(1);
                end
            end
            DP_DD_START: begin
                n_idx = '0;
                n_wr  = '0;
            end
            DP_DD_LOAD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx[AW-1:0];
            end
            DP_DD_CAND: begin
                n_cand = r_rd_data;
                n_scan = idx_p1;
                if (cand_last) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wr[AW-1:0];
                    wr_data = r_rd_data;
                    n_wr    = wr_p1;
                    n_idx   = idx_p1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_p1[AW-1:0];
                end
            end
            DP_DD_SCAN: begin
                if (scan_hit) begin
                    // a copy sits higher up, drop this one
                    n_idx = idx_p1;
                end else if (scan_last) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wr[AW-1:0];
                    wr_data = r_cand;
                    n_wr    = wr_p1;
                    n_idx   = idx_p1;
                end else begin
                    n_scan  = scan_p1;
                    rd_en   = 1'b1;
                    rd_addr = scan_p1[AW-1:0];
                end
            end
            DP_DD_END: begin
                n_count = r_wr;
            end
            DP_RO_START: begin
                n_ptr = count_m1;
            end
            DP_RO_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_ptr[AW-1:0];
            end
            DP_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_ptr    = ptr_m1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_data <= n_data;
        r_ptr  <= n_ptr;
        r_idx  <= n_idx;
        r_wr   <= n_wr;
        r_scan <= n_scan;
        r_cand <= n_cand;
        if (load_out) begin
            r_out_value  <= i_cmd.zero ? '0 : r_rd_data;
            r_out_occ    <= OCC_W'(r_count);
            r_out_status <= i_cmd.status;
            r_out_last   <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_occupancy = r_out_occ;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

### hdl/sisd_ctrl.sv
// controller state machine: sequences datapath operations per command
// depends on sisd_pkg
module sisd_ctrl import sisd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_TOP     = 4'd2;
    localparam logic [3:0] S_EMIT    = 4'd3;
    localparam logic [3:0] S_INS     = 4'd4;
    localparam logic [3:0] S_DD_LOAD = 4'd5;
    localparam logic [3:0] S_DD_CAND = 4'd6;
    localparam logic [3:0] S_DD_SCAN = 4'd7;
    localparam logic [3:0] S_RO_RD   = 4'd8;
    localparam logic [3:0] S_RO_EMIT = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic              r_zero, n_zero;

    always_comb begin
        n_state      = r_state;
        n_stat       = r_stat;
        n_zero       = r_zero;
        o_cmd.op     = DP_NOP;
        o_cmd.status = r_stat;
        o_cmd.zero   = r_zero;
        o_cmd.last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_stat = ST_OK;
                n_zero = 1'b0;
                case (i_stat.cmd)
                    CMD_PUSH: begin
                        if (i_stat.full) begin
                            n_stat = ST_FULL;
                        end else begin
                            o_cmd.op = DP_PUSH;
                        end
                        n_state = S_TOP;
                    end
                    CMD_INSERT: begin
                        if (i_stat.full) begin
                            n_stat  = ST_FULL;
                            n_state = S_TOP;
                        end else begin
                            o_cmd.op = DP_INS_START;
                            n_state  = S_INS;
                        end
                    end
                    CMD_POP: begin
                        if (i_stat.empty) begin
                            n_stat = ST_EMPTY;
                            n_zero = 1'b1;
                        end else begin
                            o_cmd.op = DP_POP;
                        end
                        n_state = S_EMIT;
                    end
                    CMD_DEDUP: begin
                        o_cmd.op = DP_DD_START;
                        n_state  = S_DD_LOAD;
                    end
                    CMD_READ: begin
                        if (i_stat.empty) begin
                            n_stat  = ST_EMPTY;
                            n_zero  = 1'b1;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.op = DP_RO_START;
                            n_state  = S_RO_RD;
                        end
                    end
                    default: begin
                        n_state = S_TOP;
                    end
                endcase
            end
            S_INS: begin
                o_cmd.op = DP_INS_STEP;
                if (!i_stat.ins_shift) begin
                    n_state = S_TOP;
                end
            end
            S_DD_LOAD: begin
                if (i_stat.dd_i_done) begin
                    o_cmd.op = DP_DD_END;
                    n_state  = S_TOP;
                end else begin
                    o_cmd.op = DP_DD_LOAD;
                    n_state  = S_DD_CAND;
                end
            end
            S_DD_CAND: begin
                o_cmd.op = DP_DD_CAND;
                n_state  = i_stat.dd_cand_last ? S_DD_LOAD : S_DD_SCAN;
            end
            S_DD_SCAN: begin
                o_cmd.op = DP_DD_SCAN;
                if (i_stat.dd_scan_hit || i_stat.dd_scan_last) begin
                    n_state = S_DD_LOAD;
                end
            end
            S_TOP: begin
                o_cmd.op = DP_RD_TOP;
                n_zero   = i_stat.empty;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.op = DP_EMIT;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RO_RD: begin
                o_cmd.op = DP_RO_RD;
                n_state  = S_RO_EMIT;
            end
            S_RO_EMIT: begin
                o_cmd.op     = DP_EMIT;
                o_cmd.status = ST_OK;
                o_cmd.zero   = 1'b0;
                o_cmd.last   = i_stat.ro_last;
                if (i_stat.out_free) begin
                    n_state = i_stat.ro_last ? S_IDLE : S_RO_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stat <= n_stat;
        r_zero <= n_zero;
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

### hdl/sorted_insert_stack_dedup_unit.sv
// top level of the sorted insert stack with duplicate removal
// depends on sisd_pkg, sisd_ctrl and sisd_datapath
//
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------------------
// input    | in        | i_in_valid / o_in_stall    | i_command, i_data_value
// result   | out       | o_out_valid / i_out_stall  | o_out_value, o_occupancy, o_status, o_last
//
// one item at a time; the entry memory has a single registered read port,
// and every step that looks at an entry waits for its read
// push, push or insert on a full stack, unused commands: decode, read of the top entry, emit
// pop, and pop or read-out on an empty stack: decode, emit
// sorted insert: entries shifted up (one shift per cycle), then the top entry is read and emitted
// duplicate removal: pairwise scan over the n entries
// read-out: entries are read and emitted one at a time from the top down
// reset (synchronous, active low) empties the stack; a stalled result holds
// the block in its emit step, and a new item is taken once the last result
// of the current one sits in the output register
module sorted_insert_stack_dedup_unit import sisd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [DATA_W-1:0] i_data_value,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic [OCC_W-1:0]         o_occupancy,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_last
);

    // micro-operation from the controller, flags back from the datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: decodes the latched command and walks the memory steps
    sisd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // entry memory, count, walk pointers and the result register
    sisd_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_command    (i_command),
        .i_data_value (i_data_value),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_value  (o_out_value),
        .o_occupancy  (o_occupancy),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

### hdl/sisd_checker.sv
// port-level checks for sorted_insert_stack_dedup_unit, with its bind
// depends on sisd_pkg
module sisd_checker import sisd_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [DATA_W-1:0] o_out_value,
    input logic [OCC_W-1:0]         o_occupancy,
    input logic [STAT_W-1:0]        o_status,
    input logic                     o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid &&
        $stable({o_out_value, o_occupancy, o_status, o_last}))
        else $error("stalled result changed");

    // an accepted item blocks the next one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    // empty status carries zero value and zero occupancy and ends the item
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |->
        o_out_value == '0 && o_occupancy == '0 && o_last)
        else $error("bad empty result");

    // a dropped push or insert leaves the stack full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_occupancy == OCC_W'(DEPTH) && o_last)
        else $error("bad full result");

    // only read-out gives non-final results, all ok from a non-empty stack
    a_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_status == ST_OK && o_occupancy != '0)
        else $error("bad read-out result");

endmodule

bind sorted_insert_stack_dedup_unit sisd_checker u_sisd_checker (.*);
